FILE: hdl/nnfs_pkg.sv
`default_nettype none
package nnfs_pkg;

  localparam int POS_W     = 8;
  localparam int CH_W      = 16;
  localparam int PIX_W     = 4 * CH_W;
  localparam int SRC_CFG_W = 7;
  localparam int DST_CFG_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int SRC_CFG_MAX = 2 ** SRC_CFG_W - 1;

  // products of a source size by an output size
  localparam int PROD_W = SRC_CFG_W + DST_CFG_W;
  // (coordinate + 1) * num
  localparam int LIM_W  = POS_W + 1 + SRC_CFG_W;
  // coordinate * num, divided by den
  localparam int DIVN_W = POS_W + SRC_CFG_W;

  localparam int DEF_MAX_SRC_W = 64;
  localparam int DEF_MAX_SRC_H = 64;

  localparam logic [SRC_CFG_W-1:0] SRC_W_RESET = SRC_CFG_W'(64);
  localparam logic [SRC_CFG_W-1:0] SRC_H_RESET = SRC_CFG_W'(64);
  localparam logic [DST_CFG_W-1:0] DST_W_RESET = DST_CFG_W'(64);
  localparam logic [DST_CFG_W-1:0] DST_H_RESET = DST_CFG_W'(64);

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // opaque white: hue 0, sat 0, light max, alpha max
  localparam logic [PIX_W-1:0] PAD_PIXEL = {16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATIO,
    ST_SELECT,
    ST_FIT,
    ST_CHECK,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load_wr;
    logic capture;
    logic ratio;
    logic select;
    logic fit;
    logic check;
    logic div_start;
    logic addr;
    logic read;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic miss;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/nnfs_ram.sv
`default_nettype none
module nnfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/nnfs_divider.sv
`default_nettype none
// Two restoring dividers sharing one divisor and one bit counter.
module nnfs_divider #(
  parameter int NUM_W = 15,
  parameter int DEN_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num_x,
  input  wire logic [NUM_W-1:0] num_y,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo_x,
  output logic      [NUM_W-1:0] quo_y,
  output logic                  done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_x, rem_y;
  logic [DEN_W:0]   trial_x, trial_y;
  logic             ge_x, ge_y;

  assign trial_x = {rem_x, quo_x[NUM_W-1]};
  assign trial_y = {rem_y, quo_y[NUM_W-1]};
  assign ge_x    = trial_x >= {1'b0, den_r};
  assign ge_y    = trial_y >= {1'b0, den_r};
  assign done    = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_x <= '0;
      rem_y <= '0;
      quo_x <= num_x;
      quo_y <= num_y;
    end else if (cnt != '0) begin
      // remainder stays below den, so the difference fits DEN_W bits
      rem_x <= ge_x ? DEN_W'(trial_x - {1'b0, den_r}) : trial_x[DEN_W-1:0];
      rem_y <= ge_y ? DEN_W'(trial_y - {1'b0, den_r}) : trial_y[DEN_W-1:0];
      quo_x <= {quo_x[NUM_W-2:0], ge_x};
      quo_y <= {quo_y[NUM_W-2:0], ge_y};
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> done)
    else $error("divider restarted while busy");
  a_start_count: assert property (@(posedge clk) disable iff (rst)
    start |=> cnt == CNT_W'(NUM_W))
    else $error("divider count not loaded");
`endif

endmodule
`default_nettype wire

FILE: hdl/nnfs_datapath.sv
`default_nettype none
module nnfs_datapath #(
  parameter int MAX_SRC_W = nnfs_pkg::DEF_MAX_SRC_W,
  parameter int MAX_SRC_H = nnfs_pkg::DEF_MAX_SRC_H
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [nnfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nnfs_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire nnfs_pkg::ctrl_cmd_t            cmd,
  output nnfs_pkg::dp_status_t                status,
  input  wire logic [79:0]                    s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [63:0]                         m_tdata,
  output logic [1:0]                          m_tuser
);
  import nnfs_pkg::*;

  localparam int STORE_DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [SRC_CFG_W-1:0] SW_LIM =
    SRC_CFG_W'((MAX_SRC_W > SRC_CFG_MAX) ? SRC_CFG_MAX : MAX_SRC_W);
  localparam logic [SRC_CFG_W-1:0] SH_LIM =
    SRC_CFG_W'((MAX_SRC_H > SRC_CFG_MAX) ? SRC_CFG_MAX : MAX_SRC_H);

  logic [SRC_CFG_W-1:0] src_width, src_height;
  logic [DST_CFG_W-1:0] dst_width, dst_height;
  logic [SRC_CFG_W-1:0] sw, sh;

  logic [POS_W-1:0]     in_x, in_y;
  logic [PIX_W-1:0]     in_pix;
  logic                 load_in_range;
  logic [ADDR_W-1:0]    load_addr;

  logic [POS_W-1:0]     pos_x, pos_y;
  logic [PROD_W-1:0]    prod_w, prod_h;
  logic [SRC_CFG_W-1:0] num;
  logic [DST_CFG_W-1:0] den;
  logic                 err;
  logic [LIM_W-1:0]     lim_xa, lim_ya;
  logic [PROD_W-1:0]    lim_xb, lim_yb;
  logic [DIVN_W-1:0]    dvd_x, dvd_y;
  logic                 pad_now, pad;

  logic [DIVN_W-1:0]    quo_x, quo_y;
  logic                 div_done;
  logic [SRC_CFG_W-1:0] sx, sy;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    ram_addr;
  logic [PIX_W-1:0]     ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_W_RESET;
      src_height <= SRC_H_RESET;
      dst_width  <= DST_W_RESET;
      dst_height <= DST_H_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data[SRC_CFG_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[SRC_CFG_W-1:0];
        REG_DST_WIDTH:  dst_width  <= cfg_data[DST_CFG_W-1:0];
        REG_DST_HEIGHT: dst_height <= cfg_data[DST_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign sw = (src_width == '0) ? SRC_CFG_W'(1) : ((src_width > SW_LIM) ? SW_LIM : src_width);
  assign sh = (src_height == '0) ? SRC_CFG_W'(1) :
              ((src_height > SH_LIM) ? SH_LIM : src_height);

  // input beat
  assign in_x   = s_tdata[7:0];
  assign in_y   = s_tdata[15:8];
  assign in_pix = s_tdata[79:16];
  assign load_in_range = (32'(in_x) < MAX_SRC_W) && (32'(in_y) < MAX_SRC_H);
  assign load_addr = ADDR_W'(32'(in_y) * MAX_SRC_W + 32'(in_x));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_x <= in_x;
      pos_y <= in_y;
    end
    if (cmd.ratio) begin
      prod_w <= PROD_W'(sw) * PROD_W'(dst_height);
      prod_h <= PROD_W'(sh) * PROD_W'(dst_width);
    end
    if (cmd.select) begin
      err <= (pos_x >= dst_width) || (pos_y >= dst_height);
      if (prod_w >= prod_h) begin
        num <= sw;
        den <= dst_width;
      end else begin
        num <= sh;
        den <= dst_height;
      end
    end
    // x >= floor(sw*den/num)  <=>  (x+1)*num > sw*den
    if (cmd.fit) begin
      lim_xa <= (LIM_W'(pos_x) + LIM_W'(1)) * LIM_W'(num);
      lim_ya <= (LIM_W'(pos_y) + LIM_W'(1)) * LIM_W'(num);
      lim_xb <= PROD_W'(sw) * PROD_W'(den);
      lim_yb <= PROD_W'(sh) * PROD_W'(den);
      dvd_x  <= DIVN_W'(pos_x) * DIVN_W'(num);
      dvd_y  <= DIVN_W'(pos_y) * DIVN_W'(num);
    end
    if (cmd.check) begin
      pad <= pad_now;
    end
    if (cmd.addr) begin
      rd_addr <= ADDR_W'(32'(sy) * MAX_SRC_W + 32'(sx));
    end
  end

  assign pad_now = (lim_xa > LIM_W'(lim_xb)) || (lim_ya > LIM_W'(lim_yb));

  nnfs_divider #(
    .NUM_W (DIVN_W),
    .DEN_W (DST_CFG_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num_x (dvd_x),
    .num_y (dvd_y),
    .den   (den),
    .quo_x (quo_x),
    .quo_y (quo_y),
    .done  (div_done)
  );

  // guard against an index past the last source column or row
  assign sx = (quo_x >= DIVN_W'(sw)) ? sw - 1'b1 : quo_x[SRC_CFG_W-1:0];
  assign sy = (quo_y >= DIVN_W'(sh)) ? sh - 1'b1 : quo_y[SRC_CFG_W-1:0];

  assign ram_addr = cmd.load_wr ? load_addr : rd_addr;

  nnfs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_wr && load_in_range),
    .re    (cmd.read),
    .addr  (ram_addr),
    .wdata (in_pix),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= (err || pad) ? PAD_PIXEL : ram_rdata;
      m_tuser <= {err, err || pad};
    end
  end

  assign status.miss     = err || pad_now;
  assign status.div_done = div_done;
  assign status.out_free = !m_tvalid || m_tready;

endmodule
`default_nettype wire

FILE: hdl/nnfs_ctrl.sv
`default_nettype none
module nnfs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tuser,
  output logic                      s_tready,
  input  wire nnfs_pkg::dp_status_t status,
  output nnfs_pkg::ctrl_cmd_t       cmd
);
  import nnfs_pkg::*;

  ctrl_state_t state, state_next;
  logic        accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tuser == REQ_READ) begin
          state_next = ST_RATIO;
        end
      end
      ST_RATIO:  state_next = ST_SELECT;
      ST_SELECT: state_next = ST_FIT;
      ST_FIT:    state_next = ST_CHECK;
      ST_CHECK:  state_next = status.miss ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR:   state_next = ST_READ;
      ST_READ:   state_next = ST_OUT;
      ST_OUT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_wr = accept && s_tuser == REQ_LOAD;
        cmd.capture = accept && s_tuser == REQ_READ;
      end
      ST_RATIO:  cmd.ratio = 1'b1;
      ST_SELECT: cmd.select = 1'b1;
      ST_FIT:    cmd.fit = 1'b1;
      ST_CHECK: begin
        cmd.check     = 1'b1;
        cmd.div_start = !status.miss;
      end
      ST_DIV:    ;
      ST_ADDR:   cmd.addr = 1'b1;
      ST_READ:   cmd.read = 1'b1;
      ST_OUT:    cmd.out_load = status.out_free;
      default:   ;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/nearest_neighbor_fit_scaler_core.sv
`default_nettype none
// Aspect-preserving nearest-neighbor scaler with letterbox padding.
// Input stream (s_*): one beat per request. s_tuser = 0 loads a source pixel
// into the frame store at (pos_x, pos_y); s_tuser = 1 reads output pixel
// (pos_x, pos_y). Loads give no output beat; each read gives exactly one.
// Output stream (m_*): HSLA pixel plus padding and coordinate-error flags.
// Config port (cfg_*): always ready; write only while no read is in flight.
// Timing: a load is written in the cycle it is accepted. A read that hits
// the fitted area passes the ratio, select, fit and check states, a 15-step
// restoring divider forming both source indices in parallel, the address
// state and the registered store read; one on padding or outside the frame
// goes from the check state straight to output. One request is in work at a
// time; s_tready is high only when the controller is idle.
// The result sits in an output register, so the next request is taken while
// m_tvalid waits on m_tready; a stalled sink holds the controller only when
// a second result is ready to be written.
// Reset restores the four size registers to 64 and empties the output
// register. Frame store contents are undefined until loaded.
module nearest_neighbor_fit_scaler_core #(
  parameter int MAX_SRC_W = nnfs_pkg::DEF_MAX_SRC_W,
  parameter int MAX_SRC_H = nnfs_pkg::DEF_MAX_SRC_H
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // pos_x[7:0], pos_y[15:8], pixel_hue[31:16], pixel_sat[47:32],
  // pixel_light[63:48], pixel_alpha[79:64]
  input  wire logic [79:0]                    s_tdata,
  // req_type
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // out_hue[15:0], out_sat[31:16], out_light[47:32], out_alpha[63:48]
  output logic [63:0]                         m_tdata,
  // is_padding[0], coord_error[1]
  output logic [1:0]                          m_tuser,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [nnfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nnfs_pkg::CFG_DAT_W-1:0] cfg_data
);
  import nnfs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  nnfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  nnfs_datapath #(
    .MAX_SRC_W (MAX_SRC_W),
    .MAX_SRC_H (MAX_SRC_H)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

`ifndef SYNTHESIS
  a_err_is_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || !m_tuser[1]))
    else $error("coordinate error without padding flag");
  a_pad_pixel: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == PAD_PIXEL))
    else $error("padding beat carries a non-padding pixel");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && m_tvalid) |-> m_tready)
    else $error("result register overwritten before it was taken");
`endif

endmodule
`default_nettype wire
